### sv/bpsa_pkg.sv
package bpsa_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int IDX_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CANDIDATES);
  localparam logic [CNT_W-1:0] BUDGET_RESET = 7'd64;
  localparam logic [31:0] MANDATORY_WEIGHT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] candidate_id;
    logic [31:0] weight;
    logic        last_candidate;
  } cand_t;

  typedef struct packed {
    logic [31:0]      result_id;
    logic [CNT_W-1:0] slot_number;
    logic             was_assigned;
    logic             is_mandatory;
    logic             final_result;
    logic [CNT_W-1:0] count_evaluated;
    logic [CNT_W-1:0] count_assigned;
    logic [CNT_W-1:0] count_exhausted;
  } result_t;

  // one stored candidate
  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT_START,
    ST_EMIT
  } state_t;

  // weight descending, then id ascending
  function automatic logic goes_before(input logic [31:0] wa, input logic [31:0] ia,
                                       input logic [31:0] wb, input logic [31:0] ib);
    logic res;
    if (wa != wb) begin
      res = (wa > wb);
    end else begin
      res = (ia < ib);
    end
    return res;
  endfunction

endpackage

### sv/bpsa_ram.sv
module bpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/budgeted_priority_slot_assigner.sv
// Budgeted priority slot assigner. Candidate requests (id, weight, last flag) are
// kept in one sorted store of MAX_CANDIDATES entries, ordered by weight descending
// and id ascending, so mandatory candidates (weight all ones) lead in id order.
// Each candidate is placed by insertion: the store is walked down from its fill
// point, one entry read, compared and moved up per cycle through the one read
// port and one write port of the store, and in_ready stays low until the
// candidate is written into its place. Candidates that arrive with the store
// full are dropped. The request flagged last starts the ordered run: once
// ST_EMIT_START has read the first entry, one result per cycle leaves (while
// out_ready is high), every candidate with its slot (1, 2, ... up to the budget
// max_layers, saturated at MAX_CANDIDATES) or slot 0, and the last result of the
// run carries the evaluated, assigned and exhausted counts. A set with no stored
// candidates gives no results. The next set may start loading while the final
// result still waits in the output register. max_layers resets to 64; the user must
// write it through cfg_we / cfg_data only while the block is idle (not enforced).
module budgeted_priority_slot_assigner (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bpsa_pkg::cand_t        in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bpsa_pkg::result_t      out_data,
  input  logic                   cfg_we,
  input  logic [6:0]             cfg_data
);

  import bpsa_pkg::*;

  state_t state, state_next;

  // fill level of the store, 0..MAX_CANDIDATES
  logic [CNT_W-1:0] fill, fill_next;
  // current hole during insertion
  logic [IDX_W-1:0] pos, pos_next;
  // entry being emitted
  logic [IDX_W-1:0] k, k_next;
  logic [CNT_W-1:0] assigned, assigned_next;
  logic [CNT_W-1:0] max_layers;
  cand_t            cand, cand_next;
  result_t          out_next;
  logic             out_load;

  // store port
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data, rd_data;

  logic [CNT_W-1:0] fill_m1;
  logic [CNT_W-1:0] budget;
  logic             got;
  logic             last_k;

  bpsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CANDIDATES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_layers <= BUDGET_RESET;
    end else if (cfg_we) begin
      max_layers <= cfg_data;
    end
  end

  assign fill_m1 = fill - CNT_W'(1);
  assign budget  = (max_layers > MAX_CNT) ? MAX_CNT : max_layers;
  assign got     = (assigned < budget);
  assign last_k  = (CNT_W'(k) == fill_m1);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    pos_next      = pos;
    k_next        = k;
    assigned_next = assigned;
    cand_next     = cand;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    out_load      = 1'b0;
    out_next      = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cand_next = in_data;
          if (fill < MAX_CNT) begin
            pos_next   = fill[IDX_W-1:0];
            state_next = ST_SHIFT;
            // fetch the entry just below the hole
            if (fill != '0) begin
              rd_en   = 1'b1;
              rd_addr = fill_m1[IDX_W-1:0];
            end
          end else if (in_data.last_candidate) begin
            // store full: request dropped, run still goes out
            state_next = ST_EMIT_START;
          end
        end
      end

      ST_SHIFT: begin
        if (pos != '0 &&
            goes_before(cand.weight, cand.candidate_id, rd_data.weight, rd_data.id)) begin
          // move the entry up one place and walk on
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = rd_data;
          pos_next = pos - IDX_W'(1);
          if (pos > IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos - IDX_W'(2);
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos;
          wr_data   = '{weight: cand.weight, id: cand.candidate_id};
          fill_next = fill + CNT_W'(1);
          state_next = cand.last_candidate ? ST_EMIT_START : ST_IDLE;
        end
      end

      ST_EMIT_START: begin
        k_next        = '0;
        assigned_next = '0;
        if (fill == '0) begin
          state_next = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // rd_data holds entry k until the output register frees up
        if (!out_valid || out_ready) begin
          out_load                 = 1'b1;
          assigned_next            = assigned + CNT_W'(got);
          out_next.result_id       = rd_data.id;
          out_next.slot_number     = got ? assigned_next : '0;
          out_next.was_assigned    = got;
          out_next.is_mandatory    = (rd_data.weight == MANDATORY_WEIGHT);
          out_next.final_result    = last_k;
          k_next                   = k + IDX_W'(1);
          if (last_k) begin
            out_next.count_evaluated = fill;
            out_next.count_assigned  = assigned_next;
            out_next.count_exhausted = fill - assigned_next;
            fill_next                = '0;
            state_next               = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = k + IDX_W'(1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    k        <= k_next;
    assigned <= assigned_next;
    cand     <= cand_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // slot given exactly when flagged assigned
  a_slot_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.was_assigned == (out_data.slot_number != '0)))
    else $error("slot number disagrees with assigned flag");

  // final counts add up
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.final_result) |->
      (out_data.count_evaluated ==
       CNT_W'(out_data.count_assigned + out_data.count_exhausted)))
    else $error("final counts inconsistent");

  // insertion hole stays inside the filled part of a non-full store
  a_hole: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (CNT_W'(pos) <= fill && fill < MAX_CNT))
    else $error("insertion position out of range");

  // emission never reads past the fill level
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (CNT_W'(k) < fill))
    else $error("emission index beyond fill level");

endmodule

### tb/sv/budgeted_priority_slot_assigner_tb.sv
`timescale 1ns / 1ps

// stand-alone check of the budgeted priority slot assigner: a directed table
// (extremes, mandatory ties, duplicate keys, budget 0/1/saturated) followed by
// random candidate sets, scored against an in-bench ordering model or typed-in results
module budgeted_priority_slot_assigner_tb;
  import bpsa_pkg::*;

  localparam int ITEM_TARGET = 470;
  // insertion walks the whole store plus emit setup, so this covers any tail
  localparam int SETTLE_CYCLES = MAX_CANDIDATES + 16;
  localparam int DRAIN_LIMIT = 200000;

  // directed table rows: a candidate scored by the model, a candidate whose
  // single result is typed in, or a budget register write
  typedef enum logic [1:0] {
    ROW_CAND,
    ROW_CAND_KNOWN,
    ROW_BUDGET
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cand_t       cand;
    logic [6:0]  budget;
    result_t     known;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  cand_t      in_data;
  logic       out_valid;
  logic       out_ready;
  result_t    out_data;
  logic       cfg_we;
  logic [6:0] cfg_data;

  // ordering model: the sorted candidate store and the slot budget
  logic [31:0] kept_id[MAX_CANDIDATES];
  logic [31:0] kept_weight[MAX_CANDIDATES];
  int          kept_count;
  logic [6:0]  budget_reg;
  result_t     fresh_run[$];

  // slot results still owed by the block, oldest first
  result_t     expected_slots[$];
  result_t     want;

  stim_row_t   directed[$];

  int mismatches;
  int items_accepted;
  int results_checked;
  int budget_writes;
  int full_sets;
  int burst_left;
  int stall_left;
  int rx_cycle;

  budgeted_priority_slot_assigner uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous wall for a hung handshake
  initial begin
    #4000000;
    $display("budgeted_priority_slot_assigner_tb: done, errors");
    $finish;
  end

  // heavier weight first, then lower id first
  function automatic logic outranks(input logic [31:0] wa, input logic [31:0] ia,
                                    input logic [31:0] wb, input logic [31:0] ib);
    if (wa != wb) begin
      return wa > wb;
    end
    return ia < ib;
  endfunction

  // insert one accepted candidate; on the last flag build the whole slot run
  task automatic absorb_candidate(input cand_t c);
    int pos;
    int slot_cap;
    int handed;
    result_t r;
    fresh_run.delete();
    // a full store silently drops the candidate
    if (kept_count < MAX_CANDIDATES) begin
      pos = kept_count;
      while (pos > 0 && outranks(c.weight, c.candidate_id,
                                 kept_weight[pos-1], kept_id[pos-1])) begin
        kept_id[pos] = kept_id[pos-1];
        kept_weight[pos] = kept_weight[pos-1];
        pos--;
      end
      kept_id[pos] = c.candidate_id;
      kept_weight[pos] = c.weight;
      kept_count++;
    end
    if (c.last_candidate) begin
      // budgets past capacity saturate
      slot_cap = (int'(budget_reg) > MAX_CANDIDATES) ? MAX_CANDIDATES : int'(budget_reg);
      handed = 0;
      for (int k = 0; k < kept_count; k++) begin
        r = '0;
        r.result_id = kept_id[k];
        if (handed < slot_cap) begin
          handed++;
          r.slot_number = 7'(handed);
          r.was_assigned = 1'b1;
        end
        r.is_mandatory = (kept_weight[k] == MANDATORY_WEIGHT);
        // counts ride only on the closing result
        if (k == kept_count - 1) begin
          r.final_result = 1'b1;
          r.count_evaluated = 7'(kept_count);
          r.count_assigned = 7'(handed);
          r.count_exhausted = 7'(kept_count - handed);
        end
        fresh_run.insert(fresh_run.size(), r);
      end
      kept_count = 0;
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // score every slot result the receiver takes
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_slots.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = expected_slots.pop_front();
        check_field("result_id", want.result_id, out_data.result_id);
        check_field("slot_number", want.slot_number, out_data.slot_number);
        check_field("was_assigned", want.was_assigned, out_data.was_assigned);
        check_field("is_mandatory", want.is_mandatory, out_data.is_mandatory);
        check_field("final_result", want.final_result, out_data.final_result);
        check_field("count_evaluated", want.count_evaluated, out_data.count_evaluated);
        check_field("count_assigned", want.count_assigned, out_data.count_assigned);
        check_field("count_exhausted", want.count_exhausted, out_data.count_exhausted);
        results_checked++;
      end
    end
  end

  // receiver: runs of full throughput, choppy ready, and long stalls in turn
  always @(negedge clk) begin
    rx_cycle++;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      case ((rx_cycle / 1500) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 24);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // sender bursts: a random run of requests, then maybe a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // hold the request until taken, then fold it into the model
  task automatic send_cand(input cand_t c, input logic use_known, input result_t known);
    pace();
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_accepted++;
    absorb_candidate(c);
    if (use_known) begin
      expected_slots.insert(expected_slots.size(), known);
    end else begin
      foreach (fresh_run[i]) expected_slots.insert(expected_slots.size(), fresh_run[i]);
    end
  endtask

  // drop valid, wait for every owed result, then let any insertion finish
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_slots.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // budget writes only land on an idle block
  task automatic change_budget(input logic [6:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    budget_reg = v;
    budget_writes++;
  endtask

  // ids lean on a few small and top values so ties and duplicates show up
  function automatic cand_t random_cand(input logic last);
    cand_t c;
    case ($urandom_range(0, 3))
      0: c.candidate_id = 32'($urandom_range(0, 7));
      1: c.candidate_id = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default: c.candidate_id = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0: c.weight = MANDATORY_WEIGHT;
      1: c.weight = 32'h0;
      2, 3: c.weight = 32'($urandom_range(0, 4));
      default: c.weight = $urandom();
    endcase
    c.last_candidate = last;
    return c;
  endfunction

  // one set; extras past a full store are dropped, the final one carries last
  task automatic run_set(input int size, input int extras);
    result_t none;
    none = '0;
    for (int i = 0; i < size; i++) begin
      send_cand(random_cand(extras == 0 && i == size - 1), 1'b0, none);
    end
    for (int e = 0; e < extras; e++) begin
      send_cand(random_cand(e == extras - 1), 1'b0, none);
    end
  endtask

  function automatic stim_row_t cand_row(input logic [31:0] id, input logic [31:0] w,
                                         input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CAND;
    r.cand = '{candidate_id: id, weight: w, last_candidate: last};
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [31:0] id, input logic [31:0] w,
                                          input result_t res);
    stim_row_t r;
    r = cand_row(id, w, 1'b1);
    r.kind = ROW_CAND_KNOWN;
    r.known = res;
    return r;
  endfunction

  function automatic stim_row_t budget_row(input logic [6:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BUDGET;
    r.budget = v;
    return r;
  endfunction

  initial begin
    int pick;
    int size;
    int extras;
    logic [6:0] nb;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    items_accepted = 0;
    results_checked = 0;
    budget_writes = 0;
    full_sets = 0;
    burst_left = 0;
    stall_left = 0;
    rx_cycle = 0;
    kept_count = 0;
    budget_reg = BUDGET_RESET;

    // single candidates at the id/weight extremes under the reset budget
    directed.insert(directed.size(), known_row(32'h5, 32'h0,
        result_t'{32'h5, 7'd1, 1'b1, 1'b0, 1'b1, 7'd1, 7'd1, 7'd0}));
    directed.insert(directed.size(), known_row(32'hFFFF_FFFF, MANDATORY_WEIGHT,
        result_t'{32'hFFFF_FFFF, 7'd1, 1'b1, 1'b1, 1'b1, 7'd1, 7'd1, 7'd0}));
    // mandatory ties ordered by id, plus a duplicate key
    directed.insert(directed.size(), cand_row(32'h0, 32'd10, 1'b0));
    directed.insert(directed.size(), cand_row(32'hFFFF_FFFF, MANDATORY_WEIGHT, 1'b0));
    directed.insert(directed.size(), cand_row(32'h7, MANDATORY_WEIGHT, 1'b0));
    directed.insert(directed.size(), cand_row(32'h3, 32'd10, 1'b0));
    directed.insert(directed.size(), cand_row(32'h3, 32'd10, 1'b0));
    directed.insert(directed.size(), cand_row(32'h1, 32'h0, 1'b1));
    // zero budget: everyone exhausted, even mandatory
    directed.insert(directed.size(), budget_row(7'd0));
    directed.insert(directed.size(), known_row(32'h9, MANDATORY_WEIGHT,
        result_t'{32'h9, 7'd0, 1'b0, 1'b1, 1'b1, 7'd1, 7'd0, 7'd1}));
    directed.insert(directed.size(), cand_row(32'h4, 32'd5, 1'b0));
    directed.insert(directed.size(), cand_row(32'h2, 32'd5, 1'b0));
    directed.insert(directed.size(), cand_row(32'h8, MANDATORY_WEIGHT, 1'b1));
    // a budget of one slot
    directed.insert(directed.size(), budget_row(7'd1));
    directed.insert(directed.size(), cand_row(32'd10, 32'd100, 1'b0));
    directed.insert(directed.size(), cand_row(32'd11, 32'd200, 1'b0));
    directed.insert(directed.size(), cand_row(32'd12, MANDATORY_WEIGHT, 1'b0));
    directed.insert(directed.size(), cand_row(32'd13, 32'h0, 1'b1));
    // top register value saturates to capacity
    directed.insert(directed.size(), budget_row(7'd127));
    directed.insert(directed.size(), known_row(32'h0, 32'h0,
        result_t'{32'h0, 7'd1, 1'b1, 1'b0, 1'b1, 7'd1, 7'd1, 7'd0}));
    directed.insert(directed.size(), cand_row(32'd20, MANDATORY_WEIGHT, 1'b0));
    directed.insert(directed.size(), cand_row(32'd21, MANDATORY_WEIGHT, 1'b0));
    directed.insert(directed.size(), cand_row(32'd22, 32'h1, 1'b1));
    directed.insert(directed.size(), budget_row(7'd64));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_BUDGET: change_budget(directed[i].budget);
        ROW_CAND_KNOWN: send_cand(directed[i].cand, 1'b1, directed[i].known);
        default: send_cand(directed[i].cand, 1'b0, '0);
      endcase
    end

    // first random set fills the store and overflows it; the stragglers are
    // dropped but the last one still starts the run
    drain();
    run_set(MAX_CANDIDATES, 2);
    full_sets++;

    while (items_accepted < ITEM_TARGET) begin
      // occasional budget change between sets, extremes included
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: nb = 7'd0;
          1: nb = 7'd1;
          2: nb = 7'd64;
          3: nb = 7'd127;
          4: nb = 7'($urandom_range(1, 8));
          default: nb = 7'($urandom_range(0, 127));
        endcase
        change_budget(nb);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // exactly full, or full with dropped stragglers
        extras = $urandom_range(0, 3);
        size = MAX_CANDIDATES;
        full_sets++;
      end else if (pick <= 3) begin
        size = $urandom_range(9, 30);
        extras = 0;
      end else begin
        size = $urandom_range(1, 8);
        extras = 0;
      end
      run_set(size, extras);
    end

    drain();
    if (expected_slots.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0 pending, got %0d",
               $time, expected_slots.size(), expected_slots.size());
      mismatches++;
    end

    $display("candidate requests taken: %0d, slot results scored: %0d", items_accepted,
             results_checked);
    $display("budget writes: %0d, sets reaching store capacity: %0d, mismatches: %0d",
             budget_writes, full_sets, mismatches);
    if (mismatches == 0) begin
      $display("budgeted_priority_slot_assigner_tb: done, clean");
    end else begin
      $display("budgeted_priority_slot_assigner_tb: done, errors");
    end
    $finish;
  end

endmodule
